/* hw/rtl/b64lw_pkg.sv */
// shared types, constants and the alphabet function for the base64 line-wrap encoder
package b64lw_pkg;

   localparam logic [7:0] CHAR_PAD = 8'h3d;
   localparam logic [7:0] CHAR_CR  = 8'h0d;
   localparam logic [7:0] CHAR_LF  = 8'h0a;

   localparam logic [5:0] LINE_GROUPS_RESET = 6'd19;

   // register word index taken from the upper paddr bit
   localparam logic REG_LINE_GROUPS = 1'b0;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       last_char;
   } rsp_type;

   // one group handed from the front to the back
   typedef struct packed {
      logic [23:0] bits;
      logic [1:0]  have;
      logic        wrap;
   } job_type;

   function automatic logic [7:0] enc_char(input logic [5:0] v);
      logic [7:0] c;
      if (v < 6'd26) begin
         c = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         c = 8'h61 + {2'b00, v} - 8'd26;
      end else if (v < 6'd62) begin
         c = 8'h30 + {2'b00, v} - 8'd52;
      end else if (v == 6'd62) begin
         c = 8'h2b;
      end else begin
         c = 8'h2f;
      end
      return c;
   endfunction

endpackage

/* hw/rtl/b64lw_front.sv */
// front end: gathers bytes into groups and decides where a line wraps
module b64lw_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_accept,
   input  b64lw_pkg::req_type  in_item,
   input  logic [5:0]          line_groups,
   output logic                job_push,
   output b64lw_pkg::job_type  job_data
);

   logic [1:0]  pos_ff,  pos_in;
   logic [15:0] held_ff, held_in;
   logic [5:0]  gil_ff,  gil_in;
   logic        done;
   logic [5:0]  gil_next;
   logic        wrap;

   always_comb begin
      pos_in   = pos_ff;
      held_in  = held_ff;
      gil_in   = gil_ff;
      done     = 1'b0;
      wrap     = 1'b0;
      gil_next = gil_ff + 6'd1;
      job_data = '0;
      job_data.have = pos_ff + 2'd1;
      unique case (pos_ff)
         2'd0:    job_data.bits = {in_item.data_byte, 16'h0000};
         2'd1:    job_data.bits = {held_ff[15:8], in_item.data_byte, 8'h00};
         default: job_data.bits = {held_ff, in_item.data_byte};
      endcase
      if (in_accept) begin
         done = in_item.final_byte || (pos_ff == 2'd2);
         if (pos_ff == 2'd0) begin
            held_in = {in_item.data_byte, 8'h00};
         end else if (pos_ff == 2'd1) begin
            held_in = {held_ff[15:8], in_item.data_byte};
         end
         if (!done) begin
            pos_in = pos_ff + 2'd1;
         end else begin
            pos_in  = 2'd0;
            held_in = 16'h0000;
            // wrap as soon as the count reaches the limit, even if it was lowered
            if (line_groups == 6'd0) begin
               gil_in = 6'd0;
            end else if (gil_next >= line_groups) begin
               wrap   = 1'b1;
               gil_in = 6'd0;
            end else begin
               gil_in = gil_next;
            end
            if (in_item.final_byte) begin
               gil_in = 6'd0;
            end
         end
      end
      job_data.wrap = wrap;
      job_push      = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= 2'd0;
         held_ff <= 16'h0000;
         gil_ff  <= 6'd0;
      end else begin
         pos_ff  <= pos_in;
         held_ff <= held_in;
         gil_ff  <= gil_in;
      end
   end

endmodule

/* hw/rtl/b64lw_fifo.sv */
// short group queue between the front and back ends
module b64lw_fifo #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  b64lw_pkg::job_type  push_data,
   input  logic                pop,
   output b64lw_pkg::job_type  head,
   output logic                empty,
   output logic                full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   b64lw_pkg::job_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign empty   = (cnt_ff == '0);
   assign full    = (cnt_ff == FULL_CNT);
   assign head    = entry_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == LAST_PTR) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == LAST_PTR) ? '0 : rd_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

/* hw/rtl/b64lw_back.sv */
// back end: walks one group out as characters into the result register
module b64lw_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_empty,
   input  b64lw_pkg::job_type  job,
   output logic                job_pop,
   output logic                out_valid,
   output b64lw_pkg::rsp_type  out_item,
   input  logic                out_pop
);

   logic [2:0]         k_ff, k_in;
   logic               valid_ff, valid_in;
   b64lw_pkg::rsp_type item_ff, item_in;
   logic               load;
   logic               job_end;
   logic [5:0]         sextet;
   logic [7:0]         ch;

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      unique case (k_ff[1:0])
         2'd0:    sextet = job.bits[23:18];
         2'd1:    sextet = job.bits[17:12];
         2'd2:    sextet = job.bits[11:6];
         default: sextet = job.bits[5:0];
      endcase
      if (k_ff == 3'd4) begin
         ch = b64lw_pkg::CHAR_CR;
      end else if (k_ff == 3'd5) begin
         ch = b64lw_pkg::CHAR_LF;
      end else if (k_ff > {1'b0, job.have}) begin
         ch = b64lw_pkg::CHAR_PAD;
      end else begin
         ch = b64lw_pkg::enc_char(sextet);
      end
      job_end = ((k_ff == 3'd3) && !job.wrap) || (k_ff == 3'd5);
      load    = !job_empty && (!valid_ff || out_pop);
      job_pop = load && job_end;

      k_in     = k_ff;
      valid_in = valid_ff && !out_pop;
      item_in  = item_ff;
      if (load) begin
         valid_in          = 1'b1;
         item_in.out_char  = ch;
         item_in.last_char = job_end;
         k_in              = job_end ? 3'd0 : k_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff     <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         k_ff     <= k_in;
         valid_ff <= valid_in;
      end
   end

endmodule

/* hw/rtl/base64_encoder_line_wrap_core.sv */
// top level of the base64 encoder with crlf line wrapping
//
//   channel   direction  handshake              payload
//   req_      in         push / full            b64lw_pkg::req_type
//   rsp_      out        pop / empty            b64lw_pkg::rsp_type
//   csr_      in         apb setup + access     line_groups at byte address 0
//
// one character leaves per cycle from the back end while the rsp_ side pops; a group is four
// characters, six with a crlf
// a byte is taken whenever it is offered while the group queue has room
// reset is synchronous, with no clearing pass
// a stalled rsp_ side backs up through the group queue into req_full
module base64_encoder_line_wrap_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  b64lw_pkg::req_type  req_data,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output b64lw_pkg::rsp_type  rsp_data,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [2:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   logic [5:0]         line_groups_ff, line_groups_in;
   logic               in_accept;
   logic               job_push;
   b64lw_pkg::job_type job_data;
   b64lw_pkg::job_type job_head;
   logic               job_pop;
   logic               job_empty;
   logic               out_valid;
   logic               csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      line_groups_in = line_groups_ff;
      if (csr_write && (csr_paddr[2] == b64lw_pkg::REG_LINE_GROUPS)) begin
         line_groups_in = csr_pwdata[5:0];
      end
      csr_prdata = '0;
      if (csr_paddr[2] == b64lw_pkg::REG_LINE_GROUPS) begin
         csr_prdata = {26'd0, line_groups_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_groups_ff <= b64lw_pkg::LINE_GROUPS_RESET;
      end else begin
         line_groups_ff <= line_groups_in;
      end
   end

   assign in_accept = req_push && !req_full;
   assign rsp_empty = !out_valid;

   b64lw_front u_front (
      .clock       (clock),
      .reset       (reset),
      .in_accept   (in_accept),
      .in_item     (req_data),
      .line_groups (line_groups_ff),
      .job_push    (job_push),
      .job_data    (job_data)
   );

   b64lw_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_data),
      .pop       (job_pop),
      .head      (job_head),
      .empty     (job_empty),
      .full      (req_full)
   );

   b64lw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_empty (job_empty),
      .job       (job_head),
      .job_pop   (job_pop),
      .out_valid (out_valid),
      .out_item  (rsp_data),
      .out_pop   (rsp_pop)
   );

endmodule

/* verif/tb_top.sv */
// testbench for the base64 line-wrap encoder: a scoreboard predicts every output character
`timescale 1ns / 100ps

module tb_top;

   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 16;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_BYTES   = 450;
   localparam logic [2:0] LINE_GROUPS_ADDR = {b64lw_pkg::REG_LINE_GROUPS, 2'b00};

   typedef enum int {POP_ALWAYS, POP_HALF, POP_SPARSE, POP_PERIODIC} pop_mode_type;

   class encoded_stream_checker;
      localparam logic [0:63][7:0] ALPHABET =
         "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

      logic [5:0]           line_groups = b64lw_pkg::LINE_GROUPS_RESET;
      logic [1:0]           bytes_held  = 2'd0;
      logic [15:0]          held        = 16'd0;
      logic [5:0]           groups_done = 6'd0;
      b64lw_pkg::rsp_type   expected_chars[$];
      int                   errors = 0;
      int                   chars_checked = 0;
      int                   line_breaks = 0;
      int                   pads = 0;

      // predicts the characters caused by one accepted byte
      function void note_byte(b64lw_pkg::req_type item);
         logic [23:0]        bits;
         logic [7:0]         chars[6];
         logic [2:0]         have;
         logic [6:0]         next_count;
         b64lw_pkg::rsp_type c;
         int                 n;
         n = 0;
         have = {1'b0, bytes_held} + 3'd1;
         if (bytes_held == 2'd0) held = {item.data_byte, 8'h00};
         else if (bytes_held == 2'd1) held[7:0] = item.data_byte;
         if (have < 3'd3 && !item.final_byte) begin
            bytes_held = have[1:0];
            return;
         end
         // missing bytes of a short group are zero filled
         bits = (have == 3'd3) ? {held, item.data_byte} : {held, 8'h00};
         for (int k = 0; k < 4; k++) begin
            chars[n] = (k > have) ? b64lw_pkg::CHAR_PAD : ALPHABET[bits[23 - 6*k -: 6]];
            n++;
         end
         if (line_groups == 6'd0) begin
            groups_done = 6'd0;
         end else begin
            next_count = {1'b0, groups_done} + 7'd1;
            if (next_count >= {1'b0, line_groups}) begin
               chars[n] = b64lw_pkg::CHAR_CR;
               chars[n + 1] = b64lw_pkg::CHAR_LF;
               n += 2;
               groups_done = 6'd0;
            end else begin
               groups_done = next_count[5:0];
            end
         end
         bytes_held = 2'd0;
         held = 16'd0;
         if (item.final_byte) groups_done = 6'd0;
         for (int i = 0; i < n; i++) begin
            c.out_char = chars[i];
            c.last_char = (i == n - 1);
            expected_chars.push_back(c);
         end
      endfunction

      function void check_char(b64lw_pkg::rsp_type got);
         b64lw_pkg::rsp_type want;
         chars_checked++;
         if (expected_chars.size() == 0) begin
            $error("unexpected transaction: out_char %02h last_char %0d",
                   got.out_char, got.last_char);
            errors++;
            return;
         end
         want = expected_chars.pop_front();
         if (got.out_char !== want.out_char) begin
            $error("out_char mismatch: expected %02h, got %02h", want.out_char, got.out_char);
            errors++;
         end
         if (got.last_char !== want.last_char) begin
            $error("last_char mismatch: expected %0d, got %0d", want.last_char, got.last_char);
            errors++;
         end
         if (want.out_char == b64lw_pkg::CHAR_LF) line_breaks++;
         if (want.out_char == b64lw_pkg::CHAR_PAD) pads++;
      endfunction

      function int pending();
         return expected_chars.size();
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_push;
   logic               req_full;
   b64lw_pkg::req_type req_data;
   logic               rsp_empty;
   logic               rsp_pop;
   b64lw_pkg::rsp_type rsp_data;
   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic [2:0]         csr_paddr;
   logic [31:0]        csr_pwdata;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   encoded_stream_checker sb = new();

   int burst_left = 0;
   bit no_gap = 0;
   bit hold_req = 0;
   int msg_left = 0;
   int bytes_sent = 0;
   int messages_sent = 0;
   int csr_writes = 0;
   int idle_cycles = 0;

   base64_encoder_line_wrap_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) sb.check_char(rsp_data);
   end

   // counts cycles in which nothing moves on any port
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) || csr_psel) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", idle_cycles);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // receiver: switches between randomly chosen stall patterns, plus one long hold-off on request
   initial begin
      int unsigned  cyc;
      pop_mode_type mode;
      cyc = 0;
      mode = POP_ALWAYS;
      rsp_pop = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 0;
         end else begin
            if (cyc % 97 == 0) mode = pop_mode_type'($urandom_range(0, 3));
            cyc++;
            case (mode)
               POP_ALWAYS: rsp_pop <= 1'b1;
               POP_HALF:   rsp_pop <= 1'($urandom_range(0, 1));
               POP_SPARSE: rsp_pop <= ($urandom_range(0, 3) == 0);
               default:    rsp_pop <= cyc[3];
            endcase
         end
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic fin);
      b64lw_pkg::req_type item;
      int                 gap;
      item.data_byte = b;
      item.final_byte = fin;
      if (!no_gap && burst_left == 0) begin
         gap = $urandom_range(1, 8);
         @(negedge clock);
         req_push <= 1'b0;
         repeat (gap - 1) @(negedge clock);
         // mostly short bursts, sometimes long stretches with no idling
         burst_left = ($urandom_range(0, 9) < 3) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 12);
      end
      if (burst_left > 0) burst_left--;
      @(negedge clock);
      req_push <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_full);
      sb.note_byte(item);
      bytes_sent++;
      if (fin) messages_sent++;
   endtask

   task automatic send_bytes(input logic [7:0] bytes[$], input logic ends_message);
      foreach (bytes[i]) send_byte(bytes[i], ends_message && (i == bytes.size() - 1));
   endtask

   // stop offering and wait until every expected character has come out
   task automatic quiesce();
      @(negedge clock);
      req_push <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= LINE_GROUPS_ADDR;
      csr_pwdata <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic check_line_groups();
      logic [31:0] rd;
      csr_access(1'b0, 32'd0, rd);
      if (rd[5:0] !== sb.line_groups) begin
         $error("line_groups mismatch: expected %0d, got %0d", sb.line_groups, rd[5:0]);
         sb.errors++;
      end
   endtask

   task automatic set_line_groups(input logic [5:0] value);
      logic [31:0] rd;
      csr_access(1'b1, {26'd0, value}, rd);
      sb.line_groups = value;
      csr_writes++;
      check_line_groups();
   endtask

   task automatic send_random_bytes(input int count);
      logic [7:0] b;
      for (int i = 0; i < count; i++) begin
         if (msg_left == 0) begin
            msg_left = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 60)
                                                   : $urandom_range(1, 12);
         end
         case ($urandom_range(0, 9))
            0:       b = 8'h00;
            1:       b = 8'hff;
            default: b = 8'($urandom_range(0, 255));
         endcase
         send_byte(b, msg_left == 1);
         msg_left--;
      end
   endtask

   initial begin
      logic [5:0] lg;
      int         phase;
      int         random_sent;
      int         phase_bytes;
      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset value, all-zero and all-one groups, both pad lengths
      check_line_groups();
      send_bytes('{8'h00, 8'h00, 8'h00}, 1'b1);
      send_bytes('{8'hff, 8'hff, 8'hff}, 1'b1);
      send_bytes('{8'hff}, 1'b1);
      send_bytes('{8'hff, 8'hff}, 1'b1);
      // register lowered to the current count mid-line, then a padded group with a wrap
      send_bytes('{8'hfb, 8'hef, 8'hbe}, 1'b0);
      quiesce();
      set_line_groups(6'd1);
      send_bytes('{8'h3e}, 1'b1);
      // wrap right after a full final group
      send_bytes('{8'h01, 8'h02, 8'h03}, 1'b1);
      quiesce();
      set_line_groups(6'd0);
      send_bytes('{8'h14, 8'hfb, 8'h9c}, 1'b1);
      quiesce();
      set_line_groups(6'd63);
      send_bytes('{8'h80}, 1'b1);
      quiesce();

      // random phases, each with its own line_groups setting
      random_sent = 0;
      phase = 0;
      while (random_sent < RANDOM_BYTES) begin
         case (phase)
            0:       lg = 6'd2;
            1:       lg = 6'd0;
            2:       lg = 6'd63;
            3:       lg = 6'd1;
            4:       lg = 6'd3;
            5:       lg = b64lw_pkg::LINE_GROUPS_RESET;
            default: lg = 6'($urandom_range(0, 63));
         endcase
         set_line_groups(lg);
         if (phase == 3) begin
            // long receiver hold-off while bytes keep coming, fills the block
            hold_req = 1;
            no_gap = 1;
            send_random_bytes(40);
            no_gap = 0;
            random_sent += 40;
         end else begin
            phase_bytes = $urandom_range(30, 70);
            send_random_bytes(phase_bytes);
            random_sent += phase_bytes;
         end
         quiesce();
         phase++;
      end
      while (msg_left != 0) begin
         send_byte(8'($urandom_range(0, 255)), msg_left == 1);
         msg_left--;
      end
      quiesce();

      if (sb.pending() != 0) begin
         $error("%0d expected characters never came out", sb.pending());
         sb.errors++;
      end
      $display("sent %0d bytes in %0d messages over %0d line_groups writes",
               bytes_sent, messages_sent, csr_writes);
      $display("checked %0d characters, %0d line breaks, %0d pad characters",
               sb.chars_checked, sb.line_breaks, sb.pads);
      if (sb.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
